FILE: sv/ictv_pkg.sv
// Shared types, constants and helpers for the IPv4/TCP checksum checker.
package ictv_pkg;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [15:0] ip_checksum;
      logic [15:0] tcp_checksum;
      logic        valid_res;
      logic [5:0]  tcp_header_offset;
      logic [15:0] packet_bytes;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] ip_sum;
      logic [16:0] tcp_sum;
      logic [15:0] total_length;
      logic [15:0] seg_length;
      logic [5:0]  hdr_bytes;
      logic [3:0]  doff_words;
      logic        proto_ok;
      logic [15:0] byte_count;
   } snap_type;

   localparam logic        CfgIgnoreIdx   = 1'b0;

   localparam logic [7:0]  ProtoTcp       = 8'd6;
   localparam logic [15:0] MinPacket      = 16'd40;
   localparam logic [15:0] MinTcpHeader   = 16'd20;
   localparam logic [15:0] SatCount       = 16'hffff;

   localparam logic [15:0] PosIhl         = 16'd0;
   localparam logic [15:0] PosOddHold     = 16'd1;
   localparam logic [15:0] PosTotLenHi    = 16'd2;
   localparam logic [15:0] PosTotLenLo    = 16'd3;
   localparam logic [15:0] PosSegFirst    = 16'd4;
   localparam logic [15:0] PosProto       = 16'd9;
   localparam logic [15:0] PosIpCsumHi    = 16'd10;
   localparam logic [15:0] PosIpCsumLo    = 16'd11;
   localparam logic [15:0] PosPseudoFirst = 16'd12;
   localparam logic [15:0] PosPseudoLast  = 16'd19;
   localparam logic [15:0] DoffOffset     = 16'd12;
   localparam logic [15:0] TcpCsumHi      = 16'd16;
   localparam logic [15:0] TcpCsumLo      = 16'd17;

   // place a byte in the high half at even offsets, low half at odd
   function automatic logic [15:0] lane_of(input logic odd, input logic [7:0] b);
      lane_of = odd ? {8'h00, b} : {b, 8'h00};
   endfunction

   // one end-around carry step on a 19-bit partial sum
   function automatic logic [16:0] fold19(input logic [18:0] s);
      fold19 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
   endfunction

endpackage

FILE: sv/ipv4_tcp_checksum_validate.sv
// Top level of the IPv4/TCP checksum checker.
// Takes one packet byte per cycle, back to back, unless a final byte waits on a stalled snapshot register;
// a marked final byte yields one result word, valid once it has passed the input register,
// the running-sum and snapshot register, and the result register.
// Reset clears the running packet state, the valid flags and the configuration register; no clearing pass.
module ipv4_tcp_checksum_validate (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ictv_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ictv_pkg::rsp_word_type rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import ictv_pkg::*;

   logic     ignore_check_fields;
   logic     snap_valid;
   logic     snap_ready;
   snap_type snap;

   ictv_csr u_csr (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .ignore_check_fields (ignore_check_fields)
   );

   ictv_accum u_accum (
      .clock               (clock),
      .reset               (reset),
      .ignore_check_fields (ignore_check_fields),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .snap_valid          (snap_valid),
      .snap_ready          (snap_ready),
      .snap                (snap)
   );

   ictv_final u_final (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |->
         rsp_data.ip_checksum == 16'd0 && rsp_data.tcp_checksum == 16'd0)
      else $error("invalid packet reports a nonzero checksum");

   a_valid_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |-> rsp_data.packet_bytes >= MinPacket)
      else $error("valid packet shorter than minimum");

   a_offset_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tcp_header_offset[1:0] == 2'b00)
      else $error("header offset not a whole number of words");

   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_ready |=> snap_valid && $stable(snap))
      else $error("snapshot lost while result register stalled");

endmodule

FILE: sv/ictv_csr.sv
// Configuration register block with APB-style access.
module ictv_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic        ignore_check_fields
);
   import ictv_pkg::*;

   logic ignore_ff;
   logic ignore_in;
   logic sel_cfg;

   assign sel_cfg = (csr_paddr[2] == CfgIgnoreIdx);

   always_comb begin
      ignore_in = ignore_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_cfg) begin
         ignore_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_ff <= 1'b0;
      end else begin
         ignore_ff <= ignore_in;
      end
   end

   assign csr_pready          = 1'b1;
   assign csr_prdata          = (csr_psel && sel_cfg) ? {31'd0, ignore_ff} : 32'd0;
   assign ignore_check_fields = ignore_ff;

endmodule

FILE: sv/ictv_accum.sv
// Input register, per-packet field capture, running checksum sums and snapshot register.
module ictv_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ignore_check_fields,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ictv_pkg::req_word_type req_data,
   output logic                  snap_valid,
   input  logic                  snap_ready,
   output ictv_pkg::snap_type    snap
);
   import ictv_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         in_move;

   logic [15:0] count_ff, count_in;
   logic [15:0] ip_ff, ip_in;
   logic [16:0] tcp_ff, tcp_in;
   logic [3:0]  hw_ff, hw_in;
   logic [15:0] tl_ff, tl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [3:0]  doff_ff, doff_in;
   logic [7:0]  even_ff, even_in;
   logic [7:0]  odd_ff, odd_in;

   logic     snap_valid_ff, snap_valid_in;
   snap_type snap_ff, snap_in;

   logic [15:0] pos;
   logic [7:0]  b;
   logic [3:0]  hw_e;
   logic [15:0] hdr16;
   logic [15:0] tl_e;
   logic [7:0]  proto_e;
   logic [3:0]  doff_e;
   logic [15:0] lane_v;
   logic [15:0] ip_v;
   logic [16:0] ip_s;
   logic [15:0] ip_e;
   logic [15:0] pseudo_v, seg_v, e0, e1, e2, e3;
   logic [18:0] tcp_s;
   logic [16:0] tcp_e;
   logic [15:0] count_e;
   logic        early;

   assign in_move   = in_valid_ff && (!in_word_ff.last_byte || !snap_valid_ff || snap_ready);
   assign req_ready = !in_valid_ff || in_move;

   always_comb begin
      pos     = count_ff;
      b       = in_word_ff.packet_byte;
      hw_e    = (pos == PosIhl) ? b[3:0] : hw_ff;
      hdr16   = {10'd0, hw_e, 2'b00};
      tl_e    = tl_ff;
      if (pos == PosTotLenHi) begin
         tl_e = {b, tl_ff[7:0]};
      end else if (pos == PosTotLenLo) begin
         tl_e = {tl_ff[15:8], b};
      end
      proto_e = (pos == PosProto) ? b : proto_ff;
      doff_e  = (pos == hdr16 + DoffOffset) ? b[7:4] : doff_ff;
      lane_v  = lane_of(pos[0], b);

      ip_v = 16'd0;
      if (pos < hdr16) begin
         ip_v = (ignore_check_fields && (pos == PosIpCsumHi || pos == PosIpCsumLo))
                ? 16'd0 : lane_v;
      end
      ip_s = {1'b0, ip_ff} + {1'b0, ip_v};
      ip_e = ip_s[15:0] + {15'd0, ip_s[16]};

      pseudo_v = (pos >= PosPseudoFirst && pos <= PosPseudoLast) ? lane_v : 16'd0;
      seg_v    = 16'd0;
      if (pos >= PosSegFirst && pos >= hdr16 && pos < tl_e) begin
         seg_v = (ignore_check_fields && (pos == hdr16 + TcpCsumHi || pos == hdr16 + TcpCsumLo))
                 ? 16'd0 : lane_v;
      end

      early = (pos == PosTotLenLo) && (hw_e == 4'd0);
      e0 = (early && tl_e > 16'd0) ? {even_ff, 8'h00}    : 16'd0;
      e1 = (early && tl_e > 16'd1) ? {8'h00, odd_ff}     : 16'd0;
      e2 = (early && tl_e > 16'd2) ? {tl_e[15:8], 8'h00} : 16'd0;
      e3 = (early && tl_e > 16'd3) ? {8'h00, b}          : 16'd0;

      tcp_s = {2'b00, tcp_ff} + {3'd0, pseudo_v} + {3'd0, seg_v}
            + {3'd0, e0} + {3'd0, e1} + {3'd0, e2} + {3'd0, e3};
      tcp_e = fold19(tcp_s);

      count_e = (count_ff == SatCount) ? count_ff : count_ff + 16'd1;
   end

   always_comb begin
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !in_move);

      count_in = count_ff;
      ip_in    = ip_ff;
      tcp_in   = tcp_ff;
      hw_in    = hw_ff;
      tl_in    = tl_ff;
      proto_in = proto_ff;
      doff_in  = doff_ff;
      even_in  = even_ff;
      odd_in   = odd_ff;
      if (in_move) begin
         if (in_word_ff.last_byte) begin
            count_in = 16'd0;
            ip_in    = 16'd0;
            tcp_in   = 17'd0;
            hw_in    = 4'd0;
            tl_in    = 16'd0;
            proto_in = 8'd0;
            doff_in  = 4'd0;
            even_in  = 8'd0;
            odd_in   = 8'd0;
         end else begin
            count_in = count_e;
            ip_in    = ip_e;
            tcp_in   = tcp_e;
            hw_in    = hw_e;
            tl_in    = tl_e;
            proto_in = proto_e;
            doff_in  = doff_e;
            even_in  = (pos == PosIhl) ? b : even_ff;
            odd_in   = (pos == PosOddHold) ? b : odd_ff;
         end
      end

      snap_valid_in = (in_move && in_word_ff.last_byte) || (snap_valid_ff && !snap_ready);
      snap_in              = snap_ff;
      if (in_move && in_word_ff.last_byte) begin
         snap_in.ip_sum       = ip_e;
         snap_in.tcp_sum      = tcp_e;
         snap_in.total_length = tl_e;
         snap_in.seg_length   = tl_e - hdr16;
         snap_in.hdr_bytes    = hdr16[5:0];
         snap_in.doff_words   = doff_e;
         snap_in.proto_ok     = (proto_e == ProtoTcp);
         snap_in.byte_count   = count_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         count_ff      <= 16'd0;
         ip_ff         <= 16'd0;
         tcp_ff        <= 17'd0;
         hw_ff         <= 4'd0;
         tl_ff         <= 16'd0;
         proto_ff      <= 8'd0;
         doff_ff       <= 4'd0;
         even_ff       <= 8'd0;
         odd_ff        <= 8'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         count_ff      <= count_in;
         ip_ff         <= ip_in;
         tcp_ff        <= tcp_in;
         hw_ff         <= hw_in;
         tl_ff         <= tl_in;
         proto_ff      <= proto_in;
         doff_ff       <= doff_in;
         even_ff       <= even_in;
         odd_ff        <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

FILE: sv/ictv_final.sv
// Packet validation, checksum completion and result register.
module ictv_final (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_valid,
   output logic                  snap_ready,
   input  ictv_pkg::snap_type    snap,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ictv_pkg::rsp_word_type rsp_data
);
   import ictv_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;
   logic         pkt_ok;
   logic [15:0]  hdr16;
   logic [15:0]  min_len;
   logic [18:0]  t_sum;
   logic [16:0]  t_fold1;
   logic [15:0]  t_fold2;

   assign snap_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      hdr16   = {10'd0, snap.hdr_bytes};
      min_len = hdr16 + {10'd0, snap.doff_words, 2'b00};
      pkt_ok  = (snap.byte_count >= MinPacket)
             && snap.proto_ok
             && (hdr16 + MinTcpHeader <= snap.byte_count)
             && (snap.total_length <= snap.byte_count)
             && (snap.total_length >= min_len);

      t_sum   = {2'b00, snap.tcp_sum} + {3'd0, snap.seg_length} + {11'd0, ProtoTcp};
      t_fold1 = fold19(t_sum);
      t_fold2 = t_fold1[15:0] + {15'd0, t_fold1[16]};

      out_in                   = out_ff;
      if (snap_valid && snap_ready) begin
         out_in.ip_checksum       = pkt_ok ? ~snap.ip_sum : 16'd0;
         out_in.tcp_checksum      = pkt_ok ? ~t_fold2 : 16'd0;
         out_in.valid_res         = pkt_ok;
         out_in.tcp_header_offset = snap.hdr_bytes;
         out_in.packet_bytes      = snap.byte_count;
      end
      out_valid_in = (snap_valid && snap_ready) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: tb/ipv4_tcp_checksum_validate_test.sv
// Self-checking testbench for the IPv4/TCP checksum checker: directed packets, then random ones.
`timescale 1ns / 1ps

module ipv4_tcp_checksum_validate_test;
   import ictv_pkg::*;

   typedef enum logic [1:0] {FillZero, FillOnes, FillRandom} fill_kind_type;

   typedef struct {
      logic [3:0]    ihl;
      logic [15:0]   tot_len;
      logic [7:0]    proto;
      logic [3:0]    doff;
      int unsigned   len;
      fill_kind_type fill;
      bit            typed;
      rsp_word_type  want;
   } packet_case_type;

   localparam logic [2:0] AddrIgnore     = {CfgIgnoreIdx, 2'b00};
   localparam int         DrainCycles    = 4;
   localparam int         LongHoldCycles = 400;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   req_word_type req_data    = '0;
   logic         rsp_ready   = 1'b0;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [2:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic         req_ready;
   logic         rsp_valid;
   rsp_word_type rsp_data;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   bit          ignore_fields;
   logic [15:0] pkt_count;
   logic [16:0] ip_acc;
   logic [16:0] tcp_acc;
   logic [3:0]  ihl_words;
   logic [15:0] tot_len;
   logic [7:0]  proto_byte;
   logic [3:0]  doff_words;
   logic [7:0]  first_byte;
   logic [7:0]  second_byte;

   rsp_word_type pending_verdicts [$];
   int           faults         = 0;
   int           verdicts_seen  = 0;
   int           words_sent     = 0;
   bit           idling_allowed = 1'b0;
   bit           req_idle_on    = 1'b0;
   bit           rsp_idle_on    = 1'b0;
   bit           stall_long     = 1'b0;

   packet_case_type cases [$] = '{
      '{4'd5,  16'd0,     8'd0,     4'd0,  1,     FillZero,   1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd1}},
      '{4'd0,  16'd0,     8'd0,     4'd0,  2,     FillZero,   1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd0, 16'd2}},
      '{4'd15, 16'hffff,  8'hff,    4'hf,  3,     FillOnes,   1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd60, 16'd3}},
      '{4'd5,  16'd39,    ProtoTcp, 4'd5,  39,    FillRandom, 1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd39}},
      '{4'd5,  16'd40,    ProtoTcp, 4'd5,  40,    FillZero,   1'b0, '0},
      '{4'd5,  16'd40,    ProtoTcp, 4'd5,  40,    FillOnes,   1'b0, '0},
      '{4'd5,  16'd60,    8'hff,    4'd5,  60,    FillRandom, 1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd60}},
      '{4'd5,  16'd60,    8'h00,    4'd5,  60,    FillOnes,   1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd60}},
      '{4'd5,  16'd100,   ProtoTcp, 4'd5,  60,    FillRandom, 1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd60}},
      '{4'd5,  16'd40,    ProtoTcp, 4'd15, 80,    FillRandom, 1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd20, 16'd80}},
      '{4'd15, 16'd70,    ProtoTcp, 4'd5,  70,    FillRandom, 1'b1,
        '{16'h0, 16'h0, 1'b0, 6'd60, 16'd70}},
      '{4'd0,  16'd40,    ProtoTcp, 4'd5,  40,    FillRandom, 1'b0, '0},
      '{4'd0,  16'd2,     ProtoTcp, 4'd0,  40,    FillRandom, 1'b0, '0},
      '{4'd0,  16'd3,     ProtoTcp, 4'd0,  40,    FillOnes,   1'b0, '0},
      '{4'd1,  16'd40,    ProtoTcp, 4'd5,  40,    FillRandom, 1'b0, '0},
      '{4'd2,  16'd48,    ProtoTcp, 4'd5,  48,    FillRandom, 1'b0, '0},
      '{4'd15, 16'd80,    ProtoTcp, 4'd5,  80,    FillOnes,   1'b0, '0},
      '{4'd15, 16'd80,    ProtoTcp, 4'd5,  80,    FillRandom, 1'b0, '0},
      '{4'd5,  16'd45,    ProtoTcp, 4'd5,  64,    FillRandom, 1'b0, '0},
      '{4'd5,  16'd41,    ProtoTcp, 4'd5,  41,    FillRandom, 1'b0, '0},
      '{4'd5,  16'd100,   ProtoTcp, 4'd15, 100,   FillRandom, 1'b0, '0}
   };

   always #6 clock = ~clock;

   ipv4_tcp_checksum_validate dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic logic [16:0] ones_add(input logic [16:0] s, input logic [15:0] v);
      logic [17:0] w;
      w = s + v;
      return w[15:0] + w[17:16];
   endfunction

   function automatic logic [15:0] lane(input bit odd, input logic [7:0] b);
      return odd ? {8'h00, b} : {b, 8'h00};
   endfunction

   function automatic void clear_packet_state();
      pkt_count   = '0;
      ip_acc      = '0;
      tcp_acc     = '0;
      ihl_words   = '0;
      tot_len     = '0;
      proto_byte  = '0;
      doff_words  = '0;
      first_byte  = '0;
      second_byte = '0;
   endfunction

   function automatic bit fold_packet_byte(input logic [7:0] b, input logic last,
                                           output rsp_word_type res);
      int unsigned pos;
      int unsigned hdr;
      int unsigned size;
      logic [15:0] v;
      logic [16:0] t;
      logic [7:0]  early [4];
      bit          ok;
      res = '0;
      pos = 32'(pkt_count);
      if (pos == PosIhl) begin
         ihl_words  = b[3:0];
         first_byte = b;
      end
      if (pos == PosOddHold) second_byte = b;
      if (pos == PosTotLenHi) tot_len[15:8] = b;
      if (pos == PosTotLenLo) tot_len[7:0] = b;
      if (pos == PosProto) proto_byte = b;
      hdr = ihl_words * 4;
      if (pos == hdr + DoffOffset) doff_words = b[7:4];
      if (pos < hdr) begin
         v = lane(pos[0], b);
         if (ignore_fields && (pos == PosIpCsumHi || pos == PosIpCsumLo)) v = '0;
         ip_acc = ones_add(ip_acc, v);
      end
      if (pos >= PosPseudoFirst && pos <= PosPseudoLast)
         tcp_acc = ones_add(tcp_acc, lane(pos[0], b));
      if (pos >= PosSegFirst) begin
         if (pos >= hdr && pos < tot_len) begin
            v = lane(pos[0], b);
            if (ignore_fields && (pos == hdr + TcpCsumHi || pos == hdr + TcpCsumLo)) v = '0;
            tcp_acc = ones_add(tcp_acc, v);
         end
      end else if (pos == PosTotLenLo && hdr == 0) begin
         early = '{first_byte, second_byte, tot_len[15:8], b};
         for (int i = 0; i < 4; i++)
            if (i < tot_len) tcp_acc = ones_add(tcp_acc, lane(i % 2 == 1, early[i]));
      end
      if (pkt_count != SatCount) pkt_count++;
      if (!last) return 1'b0;
      size = 32'(pkt_count);
      ok = size >= MinPacket && proto_byte == ProtoTcp && hdr + MinTcpHeader <= size &&
           tot_len <= size && tot_len >= hdr + doff_words * 4;
      if (ok) begin
         res.ip_checksum  = ~ip_acc[15:0];
         t = ones_add(tcp_acc, 16'(ProtoTcp));
         t = ones_add(t, 16'(tot_len - hdr));
         res.tcp_checksum = ~t[15:0];
      end
      res.valid_res         = ok;
      res.tcp_header_offset = 6'(hdr);
      res.packet_bytes      = pkt_count;
      clear_packet_state();
      return 1'b1;
   endfunction

   task automatic csr_write_check(input logic value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = AddrIgnore;
      csr_pwdata  = {31'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      ignore_fields = value;
      @(negedge clock);
      csr_psel = 1'b1;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== {31'd0, value}) begin
         $error("ignore_check_fields readback: expected %h, got %h", {31'd0, value}, csr_prdata);
         faults++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_verdicts.size() == 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic send_word(input logic [7:0] b, input logic last, input bit typed,
                            input rsp_word_type want);
      rsp_word_type got;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{packet_byte: b, last_byte: last};
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (fold_packet_byte(b, last, got)) pending_verdicts.push_back(typed ? want : got);
   endtask

   task automatic send_packet(input logic [3:0] ihl, input logic [15:0] tl,
                              input logic [7:0] proto, input logic [3:0] doff,
                              input int unsigned len, input fill_kind_type fill,
                              input bit typed, input rsp_word_type want);
      logic [7:0] b;
      req_idle_on = idling_allowed && $urandom_range(0, 3) != 0;
      rsp_idle_on = idling_allowed && $urandom_range(0, 3) != 0;
      for (int unsigned p = 0; p < len; p++) begin
         case (fill)
            FillZero: b = 8'h00;
            FillOnes: b = 8'hff;
            default:  b = 8'($urandom_range(0, 255));
         endcase
         if (p == PosIhl) b[3:0] = ihl;
         if (p == PosTotLenHi) b = tl[15:8];
         if (p == PosTotLenLo) b = tl[7:0];
         if (p == PosProto) b = proto;
         if (p == ihl * 4 + DoffOffset) b[7:4] = doff;
         send_word(b, p == len - 1, typed, want);
      end
   endtask

   task automatic send_random_packet();
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [15:0] tl;
      logic [7:0]  proto;
      int unsigned len;
      int unsigned kind;
      kind  = $urandom_range(0, 99);
      ihl   = kind < 10 ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
      doff  = kind < 15 ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
      tl    = 16'(ihl * 4 + doff * 4 + $urandom_range(0, 24));
      len   = tl + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0);
      proto = ProtoTcp;
      if (kind >= 70 && kind < 80) proto = 8'($urandom_range(0, 255));
      else if (kind >= 80 && kind < 88) tl = 16'($urandom_range(0, 65535));
      else if (kind >= 88 && kind < 94) len = $urandom_range(1, 60);
      else if (kind >= 94) begin
         ihl  = 4'($urandom_range(0, 15));
         doff = 4'($urandom_range(0, 15));
         len  = $urandom_range(1, 100);
      end
      send_packet(ihl, tl, proto, doff, len, FillRandom, 1'b0, '0);
   endtask

   task automatic run_random(input int min_words, input int min_verdicts);
      int w0;
      int v0;
      w0 = words_sent;
      v0 = verdicts_seen;
      while (words_sent - w0 < min_words || verdicts_seen - v0 < min_verdicts)
         send_random_packet();
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (stall_long) begin
            rsp_ready = 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
            stall_long = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            $error("result word with no expectation waiting: %h", rsp_data);
            faults++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.ip_checksum !== want.ip_checksum) begin
               $error("ip_checksum: expected %h, got %h", want.ip_checksum, rsp_data.ip_checksum);
               faults++;
            end
            if (rsp_data.tcp_checksum !== want.tcp_checksum) begin
               $error("tcp_checksum: expected %h, got %h", want.tcp_checksum,
                      rsp_data.tcp_checksum);
               faults++;
            end
            if (rsp_data.valid_res !== want.valid_res) begin
               $error("valid_res: expected %b, got %b", want.valid_res, rsp_data.valid_res);
               faults++;
            end
            if (rsp_data.tcp_header_offset !== want.tcp_header_offset) begin
               $error("tcp_header_offset: expected %0d, got %0d", want.tcp_header_offset,
                      rsp_data.tcp_header_offset);
               faults++;
            end
            if (rsp_data.packet_bytes !== want.packet_bytes) begin
               $error("packet_bytes: expected %0d, got %0d", want.packet_bytes,
                      rsp_data.packet_bytes);
               faults++;
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("[ipv4_tcp_checksum_validate] ERROR");
      $finish;
   end

   initial begin
      ignore_fields = 1'b0;
      clear_packet_state();
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      csr_write_check(1'b0);
      idling_allowed = 1'b1;
      foreach (cases[i])
         send_packet(cases[i].ihl, cases[i].tot_len, cases[i].proto, cases[i].doff,
                     cases[i].len, cases[i].fill, cases[i].typed, cases[i].want);
      drain();

      csr_write_check(1'b1);
      run_random(80, 0);
      drain();

      csr_write_check(1'b0);
      idling_allowed = 1'b0;
      stall_long = 1'b1;
      repeat (40)
         send_packet(4'($urandom_range(0, 15)), 16'($urandom), 8'($urandom), 4'($urandom),
                     $urandom_range(1, 2), FillRandom, 1'b0, '0);
      idling_allowed = 1'b1;
      run_random(80, 0);
      drain();

      csr_write_check(1'b1);
      idling_allowed = 1'b0;
      run_random(80, 0);
      drain();

      if (faults == 0 && pending_verdicts.size() == 0)
         $display("[ipv4_tcp_checksum_validate] OK");
      else
         $display("[ipv4_tcp_checksum_validate] ERROR");
      $finish;
   end

endmodule
